@@ rtl/core/dsu_pkg.sv @@
// shared constants, opcodes and result type for the disjoint-set engine
package dsu_pkg;

  localparam int DSU_NODES = 4096;

  localparam int OPC_W  = 2;
  localparam int NODE_W = 12;
  localparam int SIZE_W = 13;

  localparam logic [OPC_W-1:0] OP_FIND  = 2'd0;
  localparam logic [OPC_W-1:0] OP_UNITE = 2'd1;
  localparam logic [OPC_W-1:0] OP_SIZE  = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] root;
    logic              merged;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] count;
  } dsu_res_t;

endpackage

@@ rtl/core/disjoint_set_union_engine.sv @@
// Disjoint-set engine top level: parent and size memories, sequencer and result register.
// After reset the block writes the parent and size memories to their initial contents,
// with in_stall high. A find or size query walks the parent links from node_a to its root,
// rewrites the visited nodes by path compression when node_a is not the root, then reads
// the root's size and forms the result; unite also walks from node_b and then merges the
// two roots if they differ. The walk is limited by the single read port of the parent
// memory, which follows one parent link per cycle. The result register lets the next
// item be accepted while the previous result is still stalled.
module disjoint_set_union_engine
  import dsu_pkg::*;
#(
  parameter int NODES = DSU_NODES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] out_root_of_a,
  output logic              out_merged,
  output logic [SIZE_W-1:0] out_set_size_of_a,
  output logic [SIZE_W-1:0] out_component_count
);

  localparam int IDX_W = $clog2(NODES);
  localparam int SZ_W  = $clog2(NODES + 1);

  logic             in_ready;
  logic             res_take;
  dsu_res_t         res;
  logic             p_we;
  logic [IDX_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic             s_we;
  logic [IDX_W-1:0] s_waddr, s_raddr;
  logic [SZ_W-1:0]  s_wdata, s_rdata;

  logic              out_valid_r;
  logic [NODE_W-1:0] out_root_r;
  logic              out_merged_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [SIZE_W-1:0] out_count_r;

  dsu_ctrl #(.NODES(NODES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_node_a (in_node_a),
    .in_node_b (in_node_b),
    .in_ready  (in_ready),
    .res_take  (res_take),
    .res       (res),
    .p_we      (p_we),
    .p_waddr   (p_waddr),
    .p_wdata   (p_wdata),
    .p_raddr   (p_raddr),
    .p_rdata   (p_rdata),
    .s_we      (s_we),
    .s_waddr   (s_waddr),
    .s_wdata   (s_wdata),
    .s_raddr   (s_raddr),
    .s_rdata   (s_rdata)
  );

  dsu_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_parent_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  dsu_ram #(.WIDTH(SZ_W), .DEPTH(NODES)) u_size_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign in_stall = !in_ready;
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_root_r   <= res.root;
      out_merged_r <= res.merged;
      out_size_r   <= res.size;
      out_count_r  <= res.count;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_root_of_a       = out_root_r;
  assign out_merged          = out_merged_r;
  assign out_set_size_of_a   = out_size_r;
  assign out_component_count = out_count_r;

endmodule

@@ rtl/core/dsu_ram.sv @@
// generic simple dual-port ram with registered read
module dsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/dsu_ctrl.sv @@
// sequencer for find, path compression, unite and memory clearing
module dsu_ctrl
  import dsu_pkg::*;
#(
  parameter int NODES = DSU_NODES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [OPC_W-1:0]                 in_opcode,
  input  logic [NODE_W-1:0]                in_node_a,
  input  logic [NODE_W-1:0]                in_node_b,
  output logic                             in_ready,
  input  logic                             res_take,
  output dsu_res_t                         res,
  output logic                             p_we,
  output logic [$clog2(NODES)-1:0]         p_waddr,
  output logic [$clog2(NODES)-1:0]         p_wdata,
  output logic [$clog2(NODES)-1:0]         p_raddr,
  input  logic [$clog2(NODES)-1:0]         p_rdata,
  output logic                             s_we,
  output logic [$clog2(NODES)-1:0]         s_waddr,
  output logic [$clog2(NODES+1)-1:0]       s_wdata,
  output logic [$clog2(NODES)-1:0]         s_raddr,
  input  logic [$clog2(NODES+1)-1:0]       s_rdata
);

  localparam int IDX_W = $clog2(NODES);
  localparam int SZ_W  = $clog2(NODES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WALK  = 4'd2;
  localparam logic [3:0] ST_COMP  = 4'd3;
  localparam logic [3:0] ST_STB   = 4'd4;
  localparam logic [3:0] ST_SZA   = 4'd5;
  localparam logic [3:0] ST_SZB   = 4'd6;
  localparam logic [3:0] ST_MRG   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic             unite_r, unite_nxt;
  logic             second_r, second_nxt;
  logic [IDX_W-1:0] b_r, b_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0] ra_r, ra_nxt;
  logic [IDX_W-1:0] rb_r, rb_nxt;
  logic [SZ_W-1:0]  sa_r, sa_nxt;
  logic [SZ_W-1:0]  cnt_r, cnt_nxt;
  dsu_res_t         res_r, res_nxt;

  logic [IDX_W-1:0] a_in, b_in;
  logic             find_done;
  logic [IDX_W-1:0] found_root;
  logic [IDX_W-1:0] win, lose;
  logic [SZ_W-1:0]  sum;

  // indices beyond the table saturate to the last entry
  always_comb begin
    a_in = (32'(in_node_a) >= NODES) ? LAST_IDX : IDX_W'(in_node_a);
    b_in = (32'(in_node_b) >= NODES) ? LAST_IDX : IDX_W'(in_node_b);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign sum      = sa_r + s_rdata;

  always_comb begin
    if (sa_r < s_rdata) begin
      win  = rb_r;
      lose = ra_r;
    end else begin
      win  = ra_r;
      lose = rb_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    unite_nxt  = unite_r;
    second_nxt = second_r;
    b_nxt      = b_r;
    start_nxt  = start_r;
    cur_nxt    = cur_r;
    root_nxt   = root_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    sa_nxt     = sa_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    p_we       = 1'b0;
    p_waddr    = cur_r;
    p_wdata    = root_r;
    p_raddr    = cur_r;
    s_we       = 1'b0;
    s_waddr    = ra_r;
    s_wdata    = sum;
    s_raddr    = ra_r;
    find_done  = 1'b0;
    found_root = root_r;

    unique case (state_r)
      ST_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_r;
        p_wdata = clr_r;
        s_we    = 1'b1;
        s_waddr = clr_r;
        s_wdata = SZ_W'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        p_raddr = a_in;
        if (in_valid) begin
          unite_nxt  = (in_opcode == OP_UNITE);
          second_nxt = 1'b0;
          b_nxt      = b_in;
          start_nxt  = a_in;
          cur_nxt    = a_in;
          state_nxt  = ST_WALK;
        end
      end
      ST_WALK: begin
        if (p_rdata == cur_r) begin
          root_nxt = cur_r;
          if (start_r == cur_r) begin
            find_done  = 1'b1;
            found_root = cur_r;
          end else begin
            p_raddr   = start_r;
            cur_nxt   = start_r;
            state_nxt = ST_COMP;
          end
        end else begin
          p_raddr = p_rdata;
          cur_nxt = p_rdata;
        end
      end
      ST_COMP: begin
        // point the visited node straight at the root
        p_we    = 1'b1;
        p_waddr = cur_r;
        p_wdata = root_r;
        if (p_rdata == root_r) begin
          find_done  = 1'b1;
          found_root = root_r;
        end else begin
          p_raddr = p_rdata;
          cur_nxt = p_rdata;
        end
      end
      ST_STB: begin
        p_raddr   = b_r;
        cur_nxt   = b_r;
        start_nxt = b_r;
        state_nxt = ST_WALK;
      end
      ST_SZA: begin
        s_raddr   = ra_r;
        state_nxt = (unite_r && (ra_r != rb_r)) ? ST_SZB : ST_FIN;
      end
      ST_SZB: begin
        s_raddr   = rb_r;
        sa_nxt    = s_rdata;
        state_nxt = ST_MRG;
      end
      ST_MRG: begin
        p_we    = 1'b1;
        p_waddr = lose;
        p_wdata = win;
        s_we    = 1'b1;
        s_waddr = win;
        s_wdata = sum;
        if (cnt_r > SZ_W'(1)) begin
          cnt_nxt = cnt_r - SZ_W'(1);
        end
        res_nxt.root   = NODE_W'(win);
        res_nxt.merged = 1'b1;
        res_nxt.size   = SIZE_W'(sum);
        res_nxt.count  = SIZE_W'(cnt_nxt);
        state_nxt      = ST_OUT;
      end
      ST_FIN: begin
        res_nxt.root   = NODE_W'(ra_r);
        res_nxt.merged = 1'b0;
        res_nxt.size   = SIZE_W'(s_rdata);
        res_nxt.count  = SIZE_W'(cnt_r);
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (find_done) begin
      second_nxt = 1'b1;
      if (!second_r) begin
        ra_nxt = found_root;
      end else begin
        rb_nxt = found_root;
      end
      state_nxt = (unite_r && !second_r) ? ST_STB : ST_SZA;
    end

    res_nxt.valid = (state_nxt == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= SZ_W'(NODES);
      res_r.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unite_r  <= unite_nxt;
    second_r <= second_nxt;
    b_r      <= b_nxt;
    start_r  <= start_nxt;
    cur_r    <= cur_nxt;
    root_r   <= root_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    sa_r     <= sa_nxt;
  end

  assign res = res_r;

endmodule

@@ rtl/core/dsu_chk.sv @@
// port-level checker for the disjoint-set engine, bound to the top level
module dsu_chk
  import dsu_pkg::*;
#(
  parameter int NODES = DSU_NODES
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [NODE_W-1:0] out_root_of_a,
  input logic              out_merged,
  input logic [SIZE_W-1:0] out_set_size_of_a,
  input logic [SIZE_W-1:0] out_component_count
);

  logic [SIZE_W-1:0] last_cnt_r;
  logic              out_acc;

  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= SIZE_W'(NODES);
    end else if (out_acc) begin
      last_cnt_r <= out_component_count;
    end
  end

  // memory clearing keeps the input stalled right after reset
  a_clear_stall: assert property (@(posedge clk) $rose(rst_n) |-> in_stall)
    else $error("input not stalled during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_root_of_a) &&
    $stable(out_merged) && $stable(out_set_size_of_a) && $stable(out_component_count))
    else $error("stalled result changed");

  a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_merged |-> out_component_count == last_cnt_r - SIZE_W'(1))
    else $error("merge did not drop the component count by one");

  a_keep_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_merged |-> out_component_count == last_cnt_r)
    else $error("component count changed without a merge");

endmodule

bind disjoint_set_union_engine dsu_chk #(.NODES(NODES)) u_dsu_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_root_of_a       (out_root_of_a),
  .out_merged          (out_merged),
  .out_set_size_of_a   (out_set_size_of_a),
  .out_component_count (out_component_count)
);

@@ tb/sv/disjoint_set_union_engine_tb.sv @@
// self-checking testbench for the disjoint-set engine: item driver, predictor and checker
module disjoint_set_union_engine_tb;
  import dsu_pkg::*;

  localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1750;
  localparam int LONG_HOLD_AT = 500;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct {
    logic [OPC_W-1:0]  opcode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    bit                drain_first;
  } dsu_item_t;

  typedef struct {
    logic [NODE_W-1:0] root;
    logic              merged;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] count;
  } set_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OPC_W-1:0]  in_opcode = OP_FIND;
  logic [NODE_W-1:0] in_node_a = '0;
  logic [NODE_W-1:0] in_node_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NODE_W-1:0] out_root_of_a;
  logic              out_merged;
  logic [SIZE_W-1:0] out_set_size_of_a;
  logic [SIZE_W-1:0] out_component_count;

  disjoint_set_union_engine dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_node_a           (in_node_a),
    .in_node_b           (in_node_b),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_root_of_a       (out_root_of_a),
    .out_merged          (out_merged),
    .out_set_size_of_a   (out_set_size_of_a),
    .out_component_count (out_component_count)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [NODE_W-1:0] link_of [DSU_NODES];
  logic [SIZE_W-1:0] members_of [DSU_NODES];
  logic [SIZE_W-1:0] live_sets;

  dsu_item_t   pending_items [$];
  set_report_t expected_reports [$];
  int          reports_outstanding = 0;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          reports_taken = 0;
  int          send_gap = 0;
  int          hold_cycles = 0;
  bit          long_hold = 1'b0;
  int          idle_cycles = 0;

  function automatic logic [NODE_W-1:0] locate_root(logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] root;
    logic [NODE_W-1:0] walk;
    logic [NODE_W-1:0] next;
    root = node;
    while (link_of[root] != root) root = link_of[root];
    walk = node;
    while (walk != root) begin
      next = link_of[walk];
      link_of[walk] = root;
      walk = next;
    end
    return root;
  endfunction

  function automatic set_report_t apply_operation(logic [OPC_W-1:0] opcode,
                                                  logic [NODE_W-1:0] node_a,
                                                  logic [NODE_W-1:0] node_b);
    set_report_t r;
    logic [NODE_W-1:0] root_a;
    logic [NODE_W-1:0] root_b;
    logic [NODE_W-1:0] swap;
    r.merged = 1'b0;
    if (opcode == OP_UNITE) begin
      root_a = locate_root(node_a);
      root_b = locate_root(node_b);
      if (root_a != root_b) begin
        if (members_of[root_a] < members_of[root_b]) begin
          swap = root_a;
          root_a = root_b;
          root_b = swap;
        end
        link_of[root_b] = root_a;
        members_of[root_a] = members_of[root_a] + members_of[root_b];
        if (live_sets > SIZE_W'(1)) live_sets = live_sets - SIZE_W'(1);
        r.merged = 1'b1;
      end
    end else begin
      root_a = locate_root(node_a);
    end
    r.root = root_a;
    r.size = members_of[root_a];
    r.count = live_sets;
    return r;
  endfunction

  task automatic queue_item(logic [OPC_W-1:0] opcode, logic [NODE_W-1:0] node_a,
                            logic [NODE_W-1:0] node_b, bit drain_first);
    dsu_item_t it;
    it.opcode = opcode;
    it.node_a = node_a;
    it.node_b = node_b;
    it.drain_first = drain_first;
    pending_items.push_back(it);
  endtask

  function automatic logic [NODE_W-1:0] pick_node(int base, int span);
    if ($urandom_range(0, 99) < 85) return NODE_W'(base + $urandom_range(0, span));
    return NODE_W'($urandom_range(0, DSU_NODES - 1));
  endfunction

  function automatic logic [OPC_W-1:0] pick_opcode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return OP_UNITE;
    if (roll < 75) return OP_FIND;
    if (roll < 90) return OP_SIZE;
    return OP_SPARE;
  endfunction

  // sender
  always @(posedge clk) begin
    dsu_item_t it;
    bit        launched;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      launched = in_valid && !in_stall;
      if (launched) begin
        items_sent++;
        if (long_hold || ((items_sent / 128) % 4 == 3)) send_gap = 0;
        else send_gap = $urandom_range(0, 15);
      end
      if (in_valid && !launched) begin
        // stalled item stays put
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].drain_first && (in_valid || reports_outstanding != 0))) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_opcode <= it.opcode;
        in_node_a <= it.node_a;
        in_node_b <= it.node_b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      long_hold <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        reports_taken++;
        if (reports_taken == LONG_HOLD_AT) hold_cycles = LONG_HOLD_CYCLES;
        else if ((reports_taken / 128) % 4 == 1) hold_cycles = 0;
        else hold_cycles = $urandom_range(0, 15);
      end else if (hold_cycles != 0) begin
        hold_cycles--;
      end
      out_stall <= (hold_cycles != 0);
      long_hold <= (hold_cycles > 15);
    end
  end

  // checker and predictor
  always @(posedge clk) begin
    set_report_t want;
    if (!rst_n) begin
      reports_outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result with no item outstanding: root_of_a %0d", out_root_of_a);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_root_of_a !== want.root) begin
            $error("root_of_a: expected %0d, got %0d", want.root, out_root_of_a);
            mismatch_count++;
          end
          if (out_merged !== want.merged) begin
            $error("merged: expected %0d, got %0d", want.merged, out_merged);
            mismatch_count++;
          end
          if (out_set_size_of_a !== want.size) begin
            $error("set_size_of_a: expected %0d, got %0d", want.size, out_set_size_of_a);
            mismatch_count++;
          end
          if (out_component_count !== want.count) begin
            $error("component_count: expected %0d, got %0d", want.count, out_component_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_reports.push_back(apply_operation(in_opcode, in_node_a, in_node_b));
      reports_outstanding <= expected_reports.size();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("disjoint_set_union_engine verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int base;
    int span;
    for (int i = 0; i < DSU_NODES; i++) begin
      link_of[i] = NODE_W'(i);
      members_of[i] = SIZE_W'(1);
    end
    live_sets = SIZE_W'(DSU_NODES);

    // directed: extremes, every opcode, ties, same-set unite, compression
    queue_item(OP_FIND, 12'd0, 12'hFFF, 1'b0);
    queue_item(OP_FIND, 12'hFFF, 12'd0, 1'b0);
    queue_item(OP_SIZE, 12'hFFF, 12'hFFF, 1'b0);
    queue_item(OP_SPARE, 12'd2048, 12'd0, 1'b0);
    queue_item(OP_UNITE, 12'd0, 12'hFFF, 1'b0);
    queue_item(OP_UNITE, 12'hFFF, 12'd0, 1'b0);
    queue_item(OP_FIND, 12'hFFF, 12'hAAA, 1'b0);
    queue_item(OP_SIZE, 12'd0, 12'h555, 1'b0);
    queue_item(OP_UNITE, 12'd1, 12'd2, 1'b0);
    queue_item(OP_UNITE, 12'd1, 12'd0, 1'b0);
    queue_item(OP_UNITE, 12'd3, 12'hFFF, 1'b0);
    queue_item(OP_UNITE, 12'd5, 12'd6, 1'b0);
    queue_item(OP_UNITE, 12'd7, 12'd8, 1'b0);
    queue_item(OP_UNITE, 12'd5, 12'd7, 1'b0);
    queue_item(OP_FIND, 12'd8, 12'd0, 1'b0);
    queue_item(OP_FIND, 12'd8, 12'd0, 1'b0);
    queue_item(OP_SPARE, 12'd6, 12'hFFF, 1'b0);
    queue_item(OP_UNITE, 12'hAAA, 12'h555, 1'b0);
    queue_item(OP_SIZE, 12'h555, 12'hAAA, 1'b0);
    queue_item(OP_UNITE, 12'd8, 12'hFFF, 1'b0);
    queue_item(OP_SIZE, 12'd6, 12'd0, 1'b0);
    queue_item(OP_UNITE, 12'h555, 12'h555, 1'b0);

    // random: clustered node windows so that sets grow and paths deepen
    base = 0;
    span = 63;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        span = ($urandom_range(0, 3) != 0) ? 63 : 511;
        base = $urandom_range(0, DSU_NODES - 1 - span);
      end
      queue_item(pick_opcode(), pick_node(base, span), pick_node(base, span),
                 (n % 400 == 0));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so that every update of the last edge is visible
    while (pending_items.size() != 0 || in_valid || reports_outstanding != 0 ||
           expected_reports.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_reports.size() != 0) begin
      $error("results missing: %0d items without a result", expected_reports.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("disjoint_set_union_engine verification clean");
    end else begin
      $display("disjoint_set_union_engine verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/dsu_pkg.sv
rtl/core/dsu_ram.sv
rtl/core/dsu_ctrl.sv
rtl/core/disjoint_set_union_engine.sv
rtl/core/dsu_chk.sv
tb/sv/disjoint_set_union_engine_tb.sv
